// ===== src/wsw_pkg.sv =====
package wsw_pkg;

    // Stream widths (whole bytes)
    localparam int IN_TDATA_W  = 152;
    localparam int OUT_TDATA_W = 72;

    // Field widths
    localparam int IDX_W  = 6;
    localparam int BEAT_W = 64;
    localparam int TIME_W = 63;
    localparam int CNT_W  = 8;
    localparam int THR_W  = 32;

    // Configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_ADDR_W-1:0] CFG_SLOW_THR   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SLOW_LIMIT = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_WARN_THR   = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_CANCEL_THR = 2'd3;

    localparam logic [THR_W-1:0] SLOW_THR_RST   = 32'd10000;
    localparam logic [CNT_W-1:0] SLOW_LIMIT_RST = 8'd3;
    localparam logic [THR_W-1:0] WARN_THR_RST   = 32'd100000;
    localparam logic [THR_W-1:0] CANCEL_THR_RST = 32'd5000000;

    typedef struct packed {
        logic [THR_W-1:0] slow_thr;
        logic [CNT_W-1:0] slow_limit;
        logic [THR_W-1:0] warn_thr;
        logic [THR_W-1:0] cancel_thr;
    } cfg_t;

    typedef struct packed {
        logic [IDX_W-1:0]  worker_index;
        logic [BEAT_W-1:0] heartbeat;
        logic              is_bound;
        logic              in_syscall;
        logic              is_running;
        logic [TIME_W-1:0] now_us;
        logic              work_queued;
        logic              has_native_call;
        logic              native_is_fast;
        logic [CNT_W-1:0]  native_slow_count;
        logic              task_present;
        logic              cancel_already;
    } sample_t;

    // Per-worker record kept in RAM
    typedef struct packed {
        logic [BEAT_W-1:0] last_beat;
        logic [TIME_W-1:0] stall_start;
        logic              warned;
    } rec_t;

    localparam int REC_W = $bits(rec_t);

    typedef struct packed {
        logic              wake_idle;
        logic              bump_slow_count;
        logic              upgrade_to_slow;
        logic              raise_warning;
        logic              request_cancel;
        logic [TIME_W-1:0] stall_time_us;
    } result_t;

    function automatic sample_t unpack_sample(input logic [IN_TDATA_W-1:0] d);
        sample_t s;
        s.worker_index      = d[5:0];
        s.heartbeat         = d[69:6];
        s.is_bound          = d[70];
        s.in_syscall        = d[71];
        s.is_running        = d[72];
        s.now_us            = d[135:73];
        s.work_queued       = d[136];
        s.has_native_call   = d[137];
        s.native_is_fast    = d[138];
        s.native_slow_count = d[146:139];
        s.task_present      = d[147];
        s.cancel_already    = d[148];
        return s;
    endfunction

    function automatic logic [OUT_TDATA_W-1:0] pack_result(input result_t r);
        logic [OUT_TDATA_W-1:0] d;
        d       = '0;
        d[0]    = r.wake_idle;
        d[1]    = r.bump_slow_count;
        d[2]    = r.upgrade_to_slow;
        d[3]    = r.raise_warning;
        d[4]    = r.request_cancel;
        d[67:5] = r.stall_time_us;
        return d;
    endfunction

endpackage

// ===== src/wsw_ram.sv =====
module wsw_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 64
) (
    input  logic                                 aclk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic                                 re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/wsw_cfg.sv =====
module wsw_cfg (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [wsw_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [wsw_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output wsw_pkg::cfg_t                   cfg
);
    import wsw_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.slow_thr   <= SLOW_THR_RST;
            cfg_reg.slow_limit <= SLOW_LIMIT_RST;
            cfg_reg.warn_thr   <= WARN_THR_RST;
            cfg_reg.cancel_thr <= CANCEL_THR_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_SLOW_THR:   cfg_reg.slow_thr   <= cfg_wdata;
                CFG_SLOW_LIMIT: cfg_reg.slow_limit <= cfg_wdata[CNT_W-1:0];
                CFG_WARN_THR:   cfg_reg.warn_thr   <= cfg_wdata;
                CFG_CANCEL_THR: cfg_reg.cancel_thr <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== src/wsw_eval.sv =====
module wsw_eval (
    input  wsw_pkg::sample_t smp,
    input  wsw_pkg::rec_t    rec,
    input  logic             stall_valid,
    input  wsw_pkg::cfg_t    cfg,
    output wsw_pkg::rec_t    rec_next,
    output logic             stall_valid_next,
    output wsw_pkg::result_t res
);
    import wsw_pkg::*;

    logic              stalled;
    logic [TIME_W-1:0] start;
    logic [TIME_W:0]   diff;
    logic              fwd_time;
    logic [TIME_W-1:0] stall;
    logic              warned_cur;
    logic              ge_slow;
    logic              ge_warn;
    logic              ge_cancel;
    logic [CNT_W-1:0]  cnt_inc;
    logic              bump;
    logic              warn;

    assign stalled = smp.is_bound && !smp.in_syscall && smp.is_running &&
                     (smp.heartbeat == rec.last_beat) && (smp.heartbeat != '0);

    // A fresh stall starts now
    assign start      = stall_valid ? rec.stall_start : smp.now_us;
    assign warned_cur = stall_valid && rec.warned;

    assign diff     = {1'b0, smp.now_us} - {1'b0, start};
    assign fwd_time = !diff[TIME_W];
    assign stall    = fwd_time ? diff[TIME_W-1:0] : '0;

    assign ge_slow   = fwd_time && (stall >= TIME_W'(cfg.slow_thr));
    assign ge_warn   = fwd_time && (stall >= TIME_W'(cfg.warn_thr));
    assign ge_cancel = fwd_time && (stall >= TIME_W'(cfg.cancel_thr));

    assign cnt_inc = smp.native_slow_count + CNT_W'(1);
    assign bump    = ge_slow && smp.has_native_call && smp.native_is_fast;
    assign warn    = ge_warn && !warned_cur;

    always_comb begin
        res      = '0;
        rec_next = '0;
        stall_valid_next = 1'b0;
        // unbound keeps the last heartbeat, every other path records it
        rec_next.last_beat = smp.is_bound ? smp.heartbeat : rec.last_beat;
        if (stalled) begin
            stall_valid_next     = 1'b1;
            rec_next.stall_start = start;
            rec_next.warned      = warned_cur || warn;
            res.wake_idle        = !stall_valid && smp.work_queued;
            res.bump_slow_count  = bump;
            res.upgrade_to_slow  = bump && (cnt_inc >= cfg.slow_limit);
            res.raise_warning    = warn;
            res.request_cancel   = ge_cancel && smp.task_present && !smp.cancel_already;
            res.stall_time_us    = stall;
        end
    end

endmodule

// ===== src/worker_stall_watchdog.sv =====
// Heartbeat stall watchdog for up to NUM_WORKERS workers. Each sample
// transfer on the s_ side describes one worker; exactly one result transfer
// follows on the m_ side, in order. A sample is taken every cycle (one item
// per clock sustained) unless a result held on the m_ side stalls it; the
// sample's worker record is read from RAM, then evaluated into the output
// register. Samples of the same worker back to back are forwarded around
// the RAM, so any mix of workers runs at full rate. An index at or above
// NUM_WORKERS changes nothing and returns all zeros. Reset needs no
// clearing pass: per-worker valid bits make never-written records read as
// zero. Thresholds are written through the cfg_ port; the user must write
// them only while the block is idle, which the block itself does not enforce.
module worker_stall_watchdog #(
    parameter int NUM_WORKERS = 64
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // sample stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [5:0] worker_index, [69:6] heartbeat, [70] is_bound, [71] in_syscall,
    // [72] is_running, [135:73] now_us, [136] work_queued,
    // [137] has_native_call, [138] native_is_fast, [146:139] native_slow_count,
    // [147] task_present, [148] cancel_already, [151:149] zero
    input  logic [wsw_pkg::IN_TDATA_W-1:0]   s_tdata,
    // result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [0] wake_idle, [1] bump_slow_count, [2] upgrade_to_slow,
    // [3] raise_warning, [4] request_cancel, [67:5] stall_time_us, [71:68] zero
    output logic [wsw_pkg::OUT_TDATA_W-1:0]  m_tdata,
    // configuration writes
    input  logic                             cfg_we,
    input  logic [wsw_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [wsw_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import wsw_pkg::*;

    localparam int AW = (NUM_WORKERS > 1) ? $clog2(NUM_WORKERS) : 1;

    cfg_t    cfg;
    sample_t s_smp;
    logic    s_xfer;
    logic    advance;

    // stage 1: sample waiting on its RAM read
    logic    v1_reg;
    sample_t smp_reg;
    logic    in1;
    logic [AW-1:0] addr1;

    // forwarding of the record written in the same cycle a sample is taken
    logic    fwd_hit_reg;
    rec_t    fwd_rec_reg;

    logic [NUM_WORKERS-1:0] written_reg;
    logic [NUM_WORKERS-1:0] stall_valid_reg;

    logic [REC_W-1:0] ram_rdata;
    rec_t    rec_cur;
    logic    valid_cur;
    rec_t    rec_next;
    logic    stall_valid_next;
    result_t res;
    logic    wr_en;

    logic                   m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;

    wsw_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    assign s_smp    = unpack_sample(s_tdata);
    assign advance  = !m_tvalid_reg || m_tready;
    assign s_tready = !v1_reg || advance;
    assign s_xfer   = s_tvalid && s_tready;

    assign in1   = (32'(smp_reg.worker_index) < NUM_WORKERS);
    assign addr1 = smp_reg.worker_index[AW-1:0];
    assign wr_en = v1_reg && advance && in1;

    wsw_ram #(
        .WIDTH (REC_W),
        .DEPTH (NUM_WORKERS)
    ) u_ram (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (addr1),
        .wdata (rec_next),
        .re    (s_xfer),
        .raddr (s_smp.worker_index[AW-1:0]),
        .rdata (ram_rdata)
    );

    // Record source: forwarded write, RAM, or zero for a never-written worker
    always_comb begin
        if (fwd_hit_reg) begin
            rec_cur = fwd_rec_reg;
        end else if (in1 && written_reg[addr1]) begin
            rec_cur = rec_t'(ram_rdata);
        end else begin
            rec_cur = '0;
        end
    end

    assign valid_cur = in1 && stall_valid_reg[addr1];

    wsw_eval u_eval (
        .smp              (smp_reg),
        .rec              (rec_cur),
        .stall_valid      (valid_cur),
        .cfg              (cfg),
        .rec_next         (rec_next),
        .stall_valid_next (stall_valid_next),
        .res              (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg          <= 1'b0;
            fwd_hit_reg     <= 1'b0;
            written_reg     <= '0;
            stall_valid_reg <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            if (s_xfer) begin
                v1_reg      <= 1'b1;
                fwd_hit_reg <= wr_en && (s_smp.worker_index == smp_reg.worker_index);
            end else if (advance) begin
                v1_reg <= 1'b0;
            end
            if (wr_en) begin
                written_reg[addr1]     <= 1'b1;
                stall_valid_reg[addr1] <= stall_valid_next;
            end
            if (advance) begin
                m_tvalid_reg <= v1_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            smp_reg     <= s_smp;
            fwd_rec_reg <= rec_next;
        end
        if (advance && v1_reg) begin
            m_tdata_reg <= in1 ? pack_result(res) : '0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== src/wsw_checker.sv =====
module wsw_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [wsw_pkg::OUT_TDATA_W-1:0]  m_tdata
);
    import wsw_pkg::*;

    // held result keeps its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // input only backs up behind a full output register
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with output empty");

    a_upgrade: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2] |-> m_tdata[1])
        else $error("upgrade without bump");

    // a wake only comes on first detection, at zero elapsed time
    a_wake: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> m_tdata[67:5] == '0)
        else $error("wake with nonzero stall time");

endmodule

bind worker_stall_watchdog wsw_checker u_wsw_checker (.*);
